[src/dspd_pkg.sv]
// shared types and constants for the dag shortest path unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dspd_pkg;

  localparam int NODE_W = 4;
  localparam int EDGE_COST_W = 16;
  localparam int NC_W = 5;
  localparam int CTG_W = 20;

  localparam logic [NC_W-1:0] NC_RST = 5'd16;
  localparam logic [CTG_W-1:0] CTG_INF = 20'hFFFFF;
  localparam logic [CTG_W-1:0] CTG_SAT = 20'hFFFFE;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PAIR,
    ST_DRAIN,
    ST_ROW,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } dspd_state_e;

  typedef struct packed {
    logic [NODE_W-1:0]      from_node;
    logic [NODE_W-1:0]      to_node;
    logic [EDGE_COST_W-1:0] edge_cost;
    logic                   edge_present;
  } dspd_edge_t;

  typedef struct packed {
    logic [NODE_W-1:0] path_node;
    logic [CTG_W-1:0]  path_cost;
    logic              reachable;
    logic              last_node;
  } dspd_res_t;

  typedef struct packed {
    logic load_edge;
    logic init_solve;
    logic pair_rd;
    logic row_done;
    logic solve_done;
    logic emit_rd;
    logic emit_out;
  } dspd_cmd_t;

  typedef struct packed {
    logic pair_last;
    logic row_last;
    logic emit_fin;
    logic out_free;
  } dspd_sts_t;

endpackage

`default_nettype wire

[src/dag_shortest_path_dp_unit.sv]
// edge load: one transfer per cycle while idle. solve: one init step, then for each row
// one edge pair per cycle through the edge store read port, then a drain step and a row step.
// path emission per node: successor table read, then output register (held while the output stalls).
// reset clears the edge valid flags and sets node_count to 16; no clearing pass.
// top level: stream ports, controller and datapath; depends on dspd_pkg, dspd_ctrl,
// dspd_datapath
`timescale 1ns / 1ps
`default_nettype none

module dag_shortest_path_dp_unit #(
  parameter int MAX_NODES = 16,
  parameter int COST_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // from_node, to_node, edge_cost, edge_present
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // path_node, path_cost, reachable
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  import dspd_pkg::*;

  dspd_cmd_t  cmd;
  dspd_sts_t  sts;
  dspd_edge_t edge_in;
  dspd_res_t  res;

  assign edge_in.from_node    = s_axis_tdata[3:0];
  assign edge_in.to_node      = s_axis_tdata[7:4];
  assign edge_in.edge_cost    = s_axis_tdata[23:8];
  assign edge_in.edge_present = s_axis_tdata[24];

  dspd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .last_i  (s_axis_tlast),
    .ready_o (s_axis_tready),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  dspd_datapath #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_in),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'd0, res.reachable, res.path_cost, res.path_node};
  assign m_axis_tlast = res.last_node;

endmodule

`default_nettype wire

[src/dspd_ctrl.sv]
// sequencer for edge load, backward solve and path emission
// depends on dspd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dspd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic               last_i,
  output logic                    ready_o,
  input  wire dspd_pkg::dspd_sts_t sts_i,
  output dspd_pkg::dspd_cmd_t     cmd_o
);
  import dspd_pkg::*;

  dspd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (valid_i && last_i) state_d = ST_INIT;
      end
      ST_INIT: begin
        state_d = ST_PAIR;
      end
      ST_PAIR: begin
        if (sts_i.pair_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_ROW;
      end
      ST_ROW: begin
        state_d = sts_i.row_last ? ST_EMIT_RD : ST_PAIR;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (sts_i.out_free) state_d = sts_i.emit_fin ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ready_o = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        ready_o         = 1'b1;
        cmd_o.load_edge = valid_i;
      end
      ST_INIT: begin
        cmd_o.init_solve = 1'b1;
      end
      ST_PAIR: begin
        cmd_o.pair_rd = 1'b1;
      end
      ST_ROW: begin
        cmd_o.row_done   = 1'b1;
        cmd_o.solve_done = sts_i.row_last;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
      end
      ST_EMIT_OUT: begin
        cmd_o.emit_out = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/dspd_datapath.sv]
// edge store, cost-to-go and successor tables, compare unit and output register
// depends on dspd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dspd_datapath #(
  parameter int MAX_NODES = 16,
  parameter int COST_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [dspd_pkg::NC_W-1:0] cfg_wdata_i,
  input  wire dspd_pkg::dspd_edge_t    edge_i,
  input  wire dspd_pkg::dspd_cmd_t     cmd_i,
  output dspd_pkg::dspd_sts_t          sts_o,
  output logic                         res_valid_o,
  input  wire logic                    res_ready_i,
  output dspd_pkg::dspd_res_t          res_o
);
  import dspd_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW = $clog2(DEPTH);

  logic [NC_W-1:0]      nc_q;
  logic [NW-1:0]        n_last;
  logic [NW-1:0]        i_q, j_q, node_q, cnt_q;
  logic [COST_BITS-1:0] weight_mem [DEPTH];
  logic [CTG_W-1:0]     ctg_mem [MAX_NODES];
  logic [NW-1:0]        succ_mem [MAX_NODES];
  logic [DEPTH-1:0]     vld_q;
  logic [COST_BITS-1:0] w_rd_q;
  logic [CTG_W-1:0]     ctg_rd_q;
  logic [NW-1:0]        j_rd_q;
  logic                 vld_rd_q;
  logic                 eval_q;
  logic [CTG_W-1:0]     best_q;
  logic [NW-1:0]        bsucc_q;
  logic [CTG_W-1:0]     total_q;
  logic [NW-1:0]        succ_rd_q;
  logic                 out_valid_q;
  dspd_res_t            out_q;

  logic                 wr_ok;
  logic [AW-1:0]        wr_k, rd_k;
  logic [31:0]          cost32, node32;
  logic [COST_BITS-1:0] wr_w;
  logic [32:0]          sum;
  logic [CTG_W-1:0]     sat;
  logic                 take;
  logic                 reach;
  logic [NW-1:0]        next_node;
  logic                 fin;
  logic [NW-1:0]        tab_wa;
  logic [CTG_W-1:0]     ctg_wd;
  logic [NW-1:0]        succ_wd;

  always_comb begin
    if (nc_q < 5'd2) begin
      n_last = NW'(1);
    end else if (32'(nc_q) > MAX_NODES) begin
      n_last = NW'(MAX_NODES - 1);
    end else begin
      n_last = NW'(nc_q - 5'd1);
    end
  end

  // edge write address and weight
  assign wr_ok = (edge_i.to_node > edge_i.from_node) &&
                 (32'(edge_i.from_node) < MAX_NODES) &&
                 (32'(edge_i.to_node) < MAX_NODES);
  assign wr_k   = AW'(32'(edge_i.from_node) * MAX_NODES + 32'(edge_i.to_node));
  assign cost32 = 32'(edge_i.edge_cost);
  assign wr_w   = cost32[COST_BITS-1:0];
  assign rd_k   = AW'(32'(i_q) * MAX_NODES + 32'(j_q));

  // pair evaluation
  assign sum  = 33'(w_rd_q) + 33'(ctg_rd_q);
  assign sat  = (sum > 33'(CTG_SAT)) ? CTG_SAT : sum[CTG_W-1:0];
  assign take = eval_q && vld_rd_q && (ctg_rd_q != CTG_INF) && (sat < best_q);

  // path walk
  assign reach     = (total_q != CTG_INF);
  assign next_node = reach ? succ_rd_q : '0;
  assign fin       = (next_node == '0) || (cnt_q == NW'(MAX_NODES - 1));
  assign node32    = 32'(node_q);

  assign tab_wa  = cmd_i.init_solve ? n_last : i_q;
  assign ctg_wd  = cmd_i.init_solve ? '0 : best_q;
  assign succ_wd = cmd_i.init_solve ? '0 : bsucc_q;

  always_comb begin
    sts_o.pair_last = (j_q == n_last);
    sts_o.row_last  = (i_q == '0);
    sts_o.emit_fin  = fin;
    sts_o.out_free  = !out_valid_q || res_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_edge && wr_ok) weight_mem[wr_k] <= wr_w;
    if (cmd_i.init_solve || cmd_i.row_done) begin
      ctg_mem[tab_wa]  <= ctg_wd;
      succ_mem[tab_wa] <= succ_wd;
    end
    if (cmd_i.pair_rd) begin
      w_rd_q   <= weight_mem[rd_k];
      ctg_rd_q <= ctg_mem[j_q];
      vld_rd_q <= vld_q[rd_k];
      j_rd_q   <= j_q;
    end
    if (cmd_i.emit_rd) succ_rd_q <= succ_mem[node_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_solve) begin
      i_q <= n_last - NW'(1);
      j_q <= n_last;
    end else if (cmd_i.pair_rd) begin
      j_q <= j_q + NW'(1);
    end else if (cmd_i.row_done && !cmd_i.solve_done) begin
      i_q <= i_q - NW'(1);
      j_q <= i_q;
    end
    if (cmd_i.init_solve || cmd_i.row_done) begin
      best_q  <= CTG_INF;
      bsucc_q <= '0;
    end else if (take) begin
      best_q  <= sat;
      bsucc_q <= j_rd_q;
    end
    if (cmd_i.solve_done) begin
      total_q <= best_q;
      node_q  <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.emit_out) begin
      node_q <= next_node;
      cnt_q  <= cnt_q + NW'(1);
    end
    if (cmd_i.emit_out) begin
      out_q.path_node <= node32[NODE_W-1:0];
      out_q.path_cost <= total_q;
      out_q.reachable <= reach;
      out_q.last_node <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q        <= NC_RST;
      vld_q       <= '0;
      eval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) nc_q <= cfg_wdata_i;
      if (cmd_i.solve_done) begin
        vld_q <= '0;
      end else if (cmd_i.load_edge && wr_ok) begin
        vld_q[wr_k] <= edge_i.edge_present;
      end
      eval_q <= cmd_i.pair_rd;
      if (cmd_i.emit_out) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire
